// ===== rtl/pcrld_pkg.sv =====
// Shared types and constants for the palette couple run line decoder.
// No dependencies; used by the top level, pcrld_ctrl and the testbench.
`default_nettype none

package pcrld_pkg;

  localparam int LinePixelsDef = 1024;
  localparam int CoupleBitsDef = 32;

  localparam int PalDepth  = 256;
  localparam int PalAw     = 8;
  localparam int PosW      = 11;
  localparam int LenW      = 8;
  localparam int AddrW     = 9;
  localparam int ColorW    = 32;
  localparam int InDataW   = 72;
  localparam int OutDataW  = 56;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] pos;
    logic [LenW-1:0] len;
    logic            use_color;
    logic            done;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/palette_couple_run_line_decoder_top.sv =====
// Top level of the palette couple run line decoder: stream ports, palette RAM,
// token decoder, result stage with buffer wrap and output register.
// Depends on pcrld_pkg, pcrld_ram and pcrld_ctrl.
//
// Use: the slave stream carries one item per handshake; tuser selects its kind
// (palette load, line start, sprite byte). Load the palette, send a start item
// with start x and width, then stream the sprite bytes of the line. The master
// stream delivers couple writes (address, run length, color) for a line buffer;
// tlast marks the write or end marker that closes the line.
// Throughput: one item per cycle while the receiver keeps up. A result passes
// through the middle stage and then the output register; the palette RAM's
// registered read sets the middle stage. A palette entry is readable by the byte
// that follows its load. Reset clears the line state and both pipeline stages;
// palette contents stay undefined until loaded. When the receiver stalls, the output
// register holds and one more result waits in the middle stage; then s_axis_tready
// drops until the output drains.
`default_nettype none

module palette_couple_run_line_decoder_top #(
  parameter int LinePixels = pcrld_pkg::LinePixelsDef,
  parameter int CoupleBits = pcrld_pkg::CoupleBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // pal_index[7:0], pal_color[39:8], start_x[49:40], line_width[60:50],
  // data_byte[68:61], zero pad[71:69]
  input  wire logic [pcrld_pkg::InDataW-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]                     s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // couple_addr[8:0], run_len[16:9], color[48:17], zero pad[55:49]
  output logic [pcrld_pkg::OutDataW-1:0]      m_axis_tdata,
  // line_done
  output logic                                m_axis_tlast
);

  localparam int BufCouples = LinePixels / 2;
  localparam int PosW       = pcrld_pkg::PosW;
  localparam int ModSteps   = PosW - $clog2(BufCouples) + 1;

  pcrld_pkg::op_e                      opcode;
  logic                                acc;
  logic                                mv2;
  pcrld_pkg::res_t                     res;
  logic [CoupleBits-1:0]               pal_rdata;

  logic                                s1_valid_q, s1_valid_d;
  pcrld_pkg::res_t                     s1_q;
  logic                                out_valid_q, out_valid_d;
  logic [pcrld_pkg::AddrW-1:0]         out_addr_q;
  logic [pcrld_pkg::LenW-1:0]          out_len_q;
  logic [pcrld_pkg::ColorW-1:0]        out_color_q;
  logic                                out_last_q;

  logic [PosW:0]                       wrap_rem;

  assign opcode        = pcrld_pkg::op_e'(s_axis_tuser);
  assign mv2           = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || mv2;
  assign acc           = s_axis_tvalid && s_axis_tready;

  pcrld_ram #(
    .Width (CoupleBits),
    .Depth (pcrld_pkg::PalDepth)
  ) u_pal (
    .clk_i   (clk_i),
    .we_i    (acc && (opcode == pcrld_pkg::OP_LOAD)),
    .waddr_i (s_axis_tdata[7:0]),
    .wdata_i (s_axis_tdata[8 +: CoupleBits]),
    .re_i    (acc && (opcode == pcrld_pkg::OP_DATA)),
    .raddr_i (s_axis_tdata[68:61]),
    .rdata_o (pal_rdata)
  );

  pcrld_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_en_i    (acc),
    .opcode_i     (opcode),
    .start_x_i    (s_axis_tdata[49:40]),
    .line_width_i (s_axis_tdata[60:50]),
    .data_byte_i  (s_axis_tdata[68:61]),
    .res_o        (res)
  );

  // wrap the position into the line buffer by restoring subtraction
  always_comb begin
    wrap_rem = {1'b0, s1_q.pos};
    for (int k = ModSteps - 1; k >= 0; k--) begin
      if (wrap_rem >= ((PosW + 1)'(BufCouples) << k)) begin
        wrap_rem = wrap_rem - ((PosW + 1)'(BufCouples) << k);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc && res.valid) begin
      s1_valid_d = 1'b1;
    end else if (mv2) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (mv2) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= res;
    end
    if (mv2) begin
      out_addr_q  <= wrap_rem[pcrld_pkg::AddrW-1:0];
      out_len_q   <= s1_q.len;
      out_color_q <= s1_q.use_color ? pcrld_pkg::ColorW'(pal_rdata) : '0;
      out_last_q  <= s1_q.done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_color_q, out_len_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/pcrld_ram.sv =====
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
`default_nettype none

module pcrld_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pcrld_ctrl.sv =====
// Token decoder: line phase, position and counters, one decision per item.
// Depends on pcrld_pkg.
`default_nettype none

module pcrld_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        item_en_i,
  input  wire pcrld_pkg::op_e              opcode_i,
  input  wire logic [9:0]                  start_x_i,
  input  wire logic [10:0]                 line_width_i,
  input  wire logic [7:0]                  data_byte_i,
  output pcrld_pkg::res_t                  res_o
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_COUNT = 4'b0010,
    PH_FILL  = 4'b0100,
    PH_LIT   = 4'b1000
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [pcrld_pkg::PosW-1:0]      pos_q, pos_d;
  logic [pcrld_pkg::PosW-1:0]      end_q, end_d;
  logic [6:0]                      lit_q, lit_d;
  logic [pcrld_pkg::LenW-1:0]      run_q, run_d;

  logic [pcrld_pkg::PosW-1:0]      start_pos;
  logic [pcrld_pkg::PosW-1:0]      start_end;
  logic [pcrld_pkg::PosW-1:0]      fill_pos;
  logic [pcrld_pkg::PosW-1:0]      lit_pos;
  logic [6:0]                      lit_dec;
  logic                            fill_ends;
  logic                            lit_ends;

  assign start_pos = {2'b00, start_x_i[9:1]};
  assign start_end = start_pos + {1'b0, line_width_i[10:1]};
  assign fill_pos  = pos_q + {3'b000, run_q};
  assign lit_pos   = pos_q + 11'd1;
  assign lit_dec   = lit_q - 7'd1;
  assign fill_ends = (fill_pos >= end_q);
  assign lit_ends  = (lit_dec == 7'd0) && (lit_pos >= end_q);

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    end_d   = end_q;
    lit_d   = lit_q;
    run_d   = run_q;
    res_o   = '0;
    if (item_en_i) begin
      case (opcode_i)
        pcrld_pkg::OP_START: begin
          pos_d = start_pos;
          end_d = start_end;
          lit_d = '0;
          run_d = '0;
          if (start_pos >= start_end) begin
            phase_d     = PH_IDLE;
            res_o.valid = 1'b1;
            res_o.pos   = start_pos;
            res_o.done  = 1'b1;
          end else begin
            phase_d = PH_COUNT;
          end
        end
        pcrld_pkg::OP_DATA: begin
          case (phase_q)
            PH_COUNT: begin
              if (data_byte_i[7]) begin
                run_d   = ~data_byte_i + 8'd1;
                phase_d = PH_FILL;
              end else if (data_byte_i != 8'd0) begin
                lit_d   = data_byte_i[6:0];
                phase_d = PH_LIT;
              end
            end
            PH_FILL: begin
              pos_d   = fill_pos;
              phase_d = fill_ends ? PH_IDLE : PH_COUNT;
              if (data_byte_i == 8'd0) begin
                if (fill_ends) begin
                  res_o.valid = 1'b1;
                  res_o.pos   = fill_pos;
                  res_o.done  = 1'b1;
                end
              end else begin
                res_o.valid     = 1'b1;
                res_o.pos       = pos_q;
                res_o.len       = run_q;
                res_o.use_color = 1'b1;
                res_o.done      = fill_ends;
              end
            end
            PH_LIT: begin
              pos_d = lit_pos;
              lit_d = lit_dec;
              if (lit_dec == 7'd0) begin
                phase_d = lit_ends ? PH_IDLE : PH_COUNT;
              end
              if (data_byte_i == 8'd0) begin
                if (lit_ends) begin
                  res_o.valid = 1'b1;
                  res_o.pos   = lit_pos;
                  res_o.done  = 1'b1;
                end
              end else begin
                res_o.valid     = 1'b1;
                res_o.pos       = pos_q;
                res_o.len       = 8'd1;
                res_o.use_color = 1'b1;
                res_o.done      = lit_ends;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      end_q   <= '0;
      lit_q   <= '0;
      run_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      end_q   <= end_d;
      lit_q   <= lit_d;
      run_q   <= run_d;
    end
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Testbench for the palette couple run line decoder: streams palette loads,
// line starts and sprite bytes, and checks every couple write and end marker
// against its own line decoder model. Depends on pcrld_pkg and the top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pcrld_pkg::*;

  localparam int BufCouples   = LinePixelsDef / 2;
  localparam int DirRows      = 25;
  localparam int RandPerPhase = 517;
  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = 10;
  localparam int MaxPrinted   = 40;
  localparam int SendIdle [3] = '{28, 78, 0};
  localparam int RecvIdle [3] = '{78, 28, 0};

  typedef enum logic [1:0] {TK_IDLE, TK_COUNT, TK_FILL, TK_LIT} tok_phase_e;
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_MARK} chk_e;

  typedef struct packed {
    op_e               op;
    logic [PalAw-1:0]  pal_index;
    logic [ColorW-1:0] pal_color;
    logic [9:0]        start_x;
    logic [10:0]       line_width;
    logic [7:0]        data_byte;
  } sprite_item_t;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [LenW-1:0]   len;
    logic [ColorW-1:0] color;
    logic              done;
  } couple_write_t;

  typedef struct packed {
    sprite_item_t     item;
    chk_e             chk;
    logic [AddrW-1:0] mark_addr;
  } stim_row_t;

  localparam stim_row_t DirTable [DirRows] = '{
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h55}, CHK_NONE, 9'd0},
    '{'{OP_NONE,  8'd255, 32'hFFFF_FFFF, 10'd1023, 11'd2047, 8'hFF}, CHK_NONE, 9'd0},
    '{'{OP_LOAD,  8'd255, 32'hFFFF_FFFF, 10'd0,    11'd0,    8'h00}, CHK_NONE, 9'd0},
    '{'{OP_LOAD,  8'd1,   32'h1234_5678, 10'd0,    11'd0,    8'h00}, CHK_NONE, 9'd0},
    '{'{OP_LOAD,  8'd128, 32'hA5A5_5A5A, 10'd0,    11'd0,    8'h00}, CHK_NONE, 9'd0},
    '{'{OP_START, 8'd0,   32'h0000_0000, 10'd1023, 11'd0,    8'h00}, CHK_MARK, 9'd511},
    '{'{OP_START, 8'd0,   32'h0000_0000, 10'd1022, 11'd4,    8'h00}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h02}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h01}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'hFF}, CHK_PRED, 9'd0},
    '{'{OP_START, 8'd0,   32'h0000_0000, 10'd10,   11'd12,   8'h00}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h00}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'hFE}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h00}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h80}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h80}, CHK_PRED, 9'd0},
    '{'{OP_START, 8'd0,   32'h0000_0000, 10'd0,    11'd4,    8'h00}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h03}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h01}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'hFF}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h00}, CHK_MARK, 9'd3},
    '{'{OP_START, 8'd0,   32'h0000_0000, 10'd0,    11'd1024, 8'h00}, CHK_PRED, 9'd0},
    '{'{OP_START, 8'd0,   32'h0000_0000, 10'd0,    11'd2,    8'h00}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'hFD}, CHK_PRED, 9'd0},
    '{'{OP_DATA,  8'd0,   32'h0000_0000, 10'd0,    11'd0,    8'h00}, CHK_MARK, 9'd3}
  };

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  logic [ColorW-1:0] pal_shadow [PalDepth];
  bit                pal_written [PalDepth];
  logic [7:0]        pal_loaded [$];
  tok_phase_e        tok_phase;
  int unsigned       cur_pos;
  int unsigned       end_pos;
  int unsigned       fill_len;
  logic [6:0]        lits_left;

  couple_write_t pending_writes [$];
  couple_write_t want_write;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            mismatches    = 0;
  int            writes_seen   = 0;
  int            lines_closed  = 0;
  int            items_sent    = 0;
  int            cycle_count   = 0;

  palette_couple_run_line_decoder_top dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic clear_decoder();
    foreach (pal_shadow[i]) pal_shadow[i] = '0;
    tok_phase = TK_IDLE;
    cur_pos   = 0;
    end_pos   = 0;
    fill_len  = 0;
    lits_left = '0;
  endtask

  function automatic couple_write_t end_marker(input int unsigned pos);
    couple_write_t wr;
    wr      = '0;
    wr.addr = AddrW'(pos % BufCouples);
    wr.done = 1'b1;
    return wr;
  endfunction

  function automatic bit token_closes();
    if (cur_pos >= end_pos) begin
      tok_phase = TK_IDLE;
      return 1'b1;
    end
    tok_phase = TK_COUNT;
    return 1'b0;
  endfunction

  task automatic decode_item(input sprite_item_t it, output bit got, output couple_write_t wr);
    int unsigned from;
    bit          closes;
    got  = 1'b0;
    wr   = '0;
    from = cur_pos;
    case (it.op)
      OP_LOAD: begin
        pal_shadow[it.pal_index] = it.pal_color;
        if (it.pal_index != 0 && !pal_written[it.pal_index]) pal_loaded.push_back(it.pal_index);
        pal_written[it.pal_index] = 1'b1;
      end
      OP_START: begin
        cur_pos   = it.start_x >> 1;
        end_pos   = cur_pos + (it.line_width >> 1);
        lits_left = '0;
        fill_len  = 0;
        if (cur_pos >= end_pos) begin
          tok_phase = TK_IDLE;
          got       = 1'b1;
          wr        = end_marker(cur_pos);
        end else begin
          tok_phase = TK_COUNT;
        end
      end
      OP_DATA: begin
        case (tok_phase)
          TK_COUNT: begin
            if (it.data_byte[7]) begin
              fill_len  = 256 - it.data_byte;
              tok_phase = TK_FILL;
            end else if (it.data_byte != 0) begin
              lits_left = it.data_byte[6:0];
              tok_phase = TK_LIT;
            end
          end
          TK_FILL: begin
            cur_pos += fill_len;
            closes = token_closes();
            if (it.data_byte != 0) begin
              got      = 1'b1;
              wr.addr  = AddrW'(from % BufCouples);
              wr.len   = LenW'(fill_len);
              wr.color = pal_shadow[it.data_byte];
              wr.done  = closes;
            end else if (closes) begin
              got = 1'b1;
              wr  = end_marker(cur_pos);
            end
          end
          TK_LIT: begin
            cur_pos += 1;
            lits_left = lits_left - 7'd1;
            closes = (lits_left == 0) && token_closes();
            if (it.data_byte != 0) begin
              got      = 1'b1;
              wr.addr  = AddrW'(from % BufCouples);
              wr.len   = LenW'(1);
              wr.color = pal_shadow[it.data_byte];
              wr.done  = closes;
            end else if (closes) begin
              got = 1'b1;
              wr  = end_marker(cur_pos);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  function automatic logic [10:0] pick_width();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (w < 70) return 11'($urandom_range(0, 48));
    if (w < 95) return 11'($urandom_range(0, 300));
    return 11'($urandom_range(0, 1024));
  endfunction

  task automatic make_random_item(output sprite_item_t it);
    int unsigned pick;
    it.op         = OP_DATA;
    it.pal_index  = 8'($urandom_range(0, 255));
    it.pal_color  = $urandom;
    it.start_x    = 10'($urandom_range(0, 1023));
    it.line_width = 11'($urandom_range(0, 2047));
    it.data_byte  = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    case (tok_phase)
      TK_IDLE: begin
        if (pick < 70) begin
          it.op         = OP_START;
          it.line_width = pick_width();
        end else if (pick < 88) begin
          it.op = OP_LOAD;
        end else if (pick >= 96) begin
          it.op = OP_NONE;
        end
      end
      TK_COUNT: begin
        if (pick < 4) begin
          it.op = OP_LOAD;
        end else if (pick < 7) begin
          it.op         = OP_START;
          it.line_width = pick_width();
        end else if (pick < 9) begin
          it.op = OP_NONE;
        end else if (pick < 54) begin
          if ($urandom_range(0, 1) != 0) it.data_byte = 8'(256 - $urandom_range(1, 8));
          else it.data_byte = 8'($urandom_range(128, 255));
        end else if (pick < 95) begin
          if ($urandom_range(0, 99) < 80) it.data_byte = 8'($urandom_range(1, 6));
          else it.data_byte = 8'($urandom_range(1, 127));
        end else begin
          it.data_byte = 8'h00;
        end
      end
      default: begin
        if (pick < 3) begin
          it.op = OP_LOAD;
        end else if (pick < 5) begin
          it.op         = OP_START;
          it.line_width = pick_width();
        end else if (pick < 20) begin
          it.data_byte = 8'h00;
        end else begin
          it.data_byte = pal_loaded[$urandom_range(0, pal_loaded.size() - 1)];
        end
      end
    endcase
  endtask

  task automatic send_item(input sprite_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {3'b000, it.data_byte, it.line_width, it.start_x, it.pal_color,
                      it.pal_index};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got_v,
                               input logic [31:0] want_v);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch on %s: got %h, want %h (write %0d)", what, got_v, want_v, writes_seen);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_writes.size() == 0) begin
        note_mismatch("write with nothing pending", 32'(m_axis_tdata[AddrW-1:0]), '0);
      end else begin
        want_write = pending_writes.pop_front();
        if (m_axis_tdata[AddrW-1:0] !== want_write.addr)
          note_mismatch("couple_addr", 32'(m_axis_tdata[AddrW-1:0]), 32'(want_write.addr));
        if (m_axis_tdata[AddrW +: LenW] !== want_write.len)
          note_mismatch("run_len", 32'(m_axis_tdata[AddrW +: LenW]), 32'(want_write.len));
        if (m_axis_tdata[AddrW+LenW +: ColorW] !== want_write.color)
          note_mismatch("color", m_axis_tdata[AddrW+LenW +: ColorW], want_write.color);
        if (m_axis_tlast !== want_write.done)
          note_mismatch("line_done", 32'(m_axis_tlast), 32'(want_write.done));
      end
      writes_seen++;
      if (m_axis_tlast === 1'b1) lines_closed++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d writes outstanding", pending_writes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    sprite_item_t  it;
    couple_write_t wr;
    bit            got;
    int            counted;
    clear_decoder();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = SendIdle[0];
    recv_idle_pct <= RecvIdle[0];
    for (int r = 0; r < DirRows; r++) begin
      decode_item(DirTable[r].item, got, wr);
      case (DirTable[r].chk)
        CHK_PRED: if (got) pending_writes.push_back(wr);
        CHK_MARK: pending_writes.push_back(end_marker(DirTable[r].mark_addr));
        default: ;
      endcase
      send_item(DirTable[r].item);
      items_sent++;
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = SendIdle[ph];
      recv_idle_pct <= RecvIdle[ph];
      counted = 0;
      while (counted < RandPerPhase) begin
        make_random_item(it);
        if (!(it.op == OP_NONE || (it.op == OP_DATA && tok_phase == TK_IDLE))) counted++;
        decode_item(it, got, wr);
        if (got) pending_writes.push_back(wr);
        send_item(it);
        items_sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("ran %0d items under three idle mixes: %0d couple writes compared, %0d lines ended",
             items_sent, writes_seen, lines_closed);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
